FILE: design/mp2d_pkg.sv
package mp2d_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_WINDOW = 8;
    localparam int DEF_DATA_BITS  = 16;

    // Configuration channel
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;

    // Register field widths
    localparam int WINDOW_REG_BITS = 4;
    localparam int STRIDE_BITS     = 4;
    localparam int WIDTH_REG_BITS  = 9;
    localparam int HEIGHT_BITS     = 9;
    localparam int COUNT_BITS      = 11;

    // Map geometry limits that do not follow from parameters
    localparam int MAX_ROWS     = 256;
    localparam int MAX_CHANNELS = 1024;
    localparam int ROW_BITS     = 8;
    localparam int CHAN_BITS    = 10;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_WINDOW   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_STRIDE   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 3'd4;

endpackage

FILE: design/mp2d_if.sv
interface mp2d_sample_if #(
    parameter int DATA_BITS = mp2d_pkg::DEF_DATA_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mp2d_result_if #(
    parameter int DATA_BITS = mp2d_pkg::DEF_DATA_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] pooled_max;
    logic                        last_of_volume;

    modport source (output valid, output pooled_max, output last_of_volume, input ready);
    modport sink   (input valid, input pooled_max, input last_of_volume, output ready);
endinterface

interface mp2d_cfg_if;
    import mp2d_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/max_pool_2d_stream.sv
// Streaming 2-D max pooling, valid windows only. Samples arrive channel by
// channel, row by row, column fastest; one sample is taken every cycle with
// no gaps unless back-pressure holds window results in both the output
// register and stage 2. A window maximum passes stage 1, stage 2 and the
// output register after its bottom-right sample. The rate is set by the line
// buffer: one bank per stored row (MAX_WINDOW-1 banks of MAX_WIDTH entries),
// all read at the current column and one written in the same cycle. The line
// buffer is not cleared after reset and needs no clearing pass. A write to
// any of the five registers restarts the volume at channel 0, row 0, column
// 0; write configuration only while the pipeline is empty.
module max_pool_2d_stream #(
    parameter int MAX_WIDTH  = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = mp2d_pkg::DEF_MAX_WINDOW,
    parameter int DATA_BITS  = mp2d_pkg::DEF_DATA_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    mp2d_sample_if.sink        samples,
    mp2d_result_if.source      results,
    mp2d_cfg_if.sink           cfg
);
    import mp2d_pkg::*;

    localparam int LINES    = (MAX_WINDOW > 1) ? (MAX_WINDOW - 1) : 1;
    localparam int SB       = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WDB      = $clog2(MAX_WIDTH + 1);
    localparam int WB       = $clog2(MAX_WINDOW + 1);
    localparam int W_RESET  = (MAX_WINDOW < 2) ? MAX_WINDOW : 2;
    localparam int WD_RESET = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

    // Effective configuration (already clamped)
    logic [WB-1:0]          w_eff_reg;
    logic [STRIDE_BITS-1:0] s_eff_reg;
    logic [WDB-1:0]         wd_eff_reg;
    logic [HEIGHT_BITS-1:0] ht_eff_reg;
    logic [COUNT_BITS-1:0]  ch_eff_reg;

    // Position of the next sample
    logic [CW-1:0]          col_reg,   col_next;
    logic [ROW_BITS-1:0]    row_reg,   row_next;
    logic [CHAN_BITS-1:0]   chan_reg,  chan_next;
    logic [STRIDE_BITS-1:0] cph_reg,   cph_next;
    logic [STRIDE_BITS-1:0] rph_reg,   rph_next;
    logic [SB-1:0]          wslot_reg, wslot_next;

    // Stage 1: line buffer read data and the sample
    logic                        s1_valid_reg;
    logic signed [DATA_BITS-1:0] s1_sample_reg;
    logic [SB-1:0]               s1_slot_reg;
    logic                        s1_vert_reg;
    logic                        s1_emit_reg;
    logic                        s1_last_reg;

    // Stage 2: column maxima shifted in
    logic                        s2_valid_reg;
    logic                        s2_emit_reg;
    logic                        s2_last_reg;
    logic signed [DATA_BITS-1:0] colmax_reg [MAX_WINDOW];

    // Output register
    logic                        out_valid_reg;
    logic signed [DATA_BITS-1:0] out_max_reg;
    logic                        out_last_reg;

    logic signed [DATA_BITS-1:0] line_rd [LINES];
    logic signed [DATA_BITS-1:0] vmax;
    logic signed [DATA_BITS-1:0] wmax;
    logic [SB-1:0]               rd_idx;

    logic accept, cfg_write;
    logic out_free, s2_go, s2_free, s1_go, s1_free;
    logic row_ok, col_ok, emit, last, col_wrap, row_wrap;

    // ---------------------------------------------------------------
    // Handshake and stage advance
    // ---------------------------------------------------------------
    assign out_free = !out_valid_reg || results.ready;
    assign s2_go    = s2_valid_reg && (!s2_emit_reg || out_free);
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;

    assign samples.ready = s1_free;
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_write     = cfg.valid && cfg.ready;

    assign results.valid          = out_valid_reg;
    assign results.pooled_max     = out_max_reg;
    assign results.last_of_volume = out_last_reg;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg  <= WB'(W_RESET);
            s_eff_reg  <= STRIDE_BITS'(2);
            wd_eff_reg <= WDB'(WD_RESET);
            ht_eff_reg <= HEIGHT_BITS'(MAX_ROWS);
            ch_eff_reg <= COUNT_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                REG_POOL_WINDOW:
                begin
                    if (cfg.data[WINDOW_REG_BITS-1:0] == '0)
                        w_eff_reg <= WB'(1);
                    else if (int'(cfg.data[WINDOW_REG_BITS-1:0]) > MAX_WINDOW)
                        w_eff_reg <= WB'(MAX_WINDOW);
                    else
                        w_eff_reg <= WB'(cfg.data[WINDOW_REG_BITS-1:0]);
                end
                REG_POOL_STRIDE:
                begin
                    if (cfg.data[STRIDE_BITS-1:0] == '0)
                        s_eff_reg <= STRIDE_BITS'(1);
                    else
                        s_eff_reg <= cfg.data[STRIDE_BITS-1:0];
                end
                REG_MAP_WIDTH:
                begin
                    if (cfg.data[WIDTH_REG_BITS-1:0] == '0)
                        wd_eff_reg <= WDB'(1);
                    else if (int'(cfg.data[WIDTH_REG_BITS-1:0]) > MAX_WIDTH)
                        wd_eff_reg <= WDB'(MAX_WIDTH);
                    else
                        wd_eff_reg <= WDB'(cfg.data[WIDTH_REG_BITS-1:0]);
                end
                REG_MAP_HEIGHT:
                begin
                    if (cfg.data[HEIGHT_BITS-1:0] == '0)
                        ht_eff_reg <= HEIGHT_BITS'(1);
                    else if (int'(cfg.data[HEIGHT_BITS-1:0]) > MAX_ROWS)
                        ht_eff_reg <= HEIGHT_BITS'(MAX_ROWS);
                    else
                        ht_eff_reg <= cfg.data[HEIGHT_BITS-1:0];
                end
                REG_CHANNEL_COUNT:
                begin
                    if (cfg.data[COUNT_BITS-1:0] == '0)
                        ch_eff_reg <= COUNT_BITS'(1);
                    else if (int'(cfg.data[COUNT_BITS-1:0]) > MAX_CHANNELS)
                        ch_eff_reg <= COUNT_BITS'(MAX_CHANNELS);
                    else
                        ch_eff_reg <= cfg.data[COUNT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Position tracking; phases hold (pos + 1 - window) mod stride
    // ---------------------------------------------------------------
    assign row_ok   = (int'(row_reg) + 1) >= int'(w_eff_reg);
    assign col_ok   = (int'(col_reg) + 1) >= int'(w_eff_reg);
    assign emit     = row_ok && col_ok && (rph_reg == '0) && (cph_reg == '0);
    assign last     = (int'(chan_reg) == int'(ch_eff_reg) - 1)
                   && (int'(row_reg) + 1 + int'(s_eff_reg) > int'(ht_eff_reg))
                   && (int'(col_reg) + 1 + int'(s_eff_reg) > int'(wd_eff_reg));
    assign col_wrap = (int'(col_reg) + 1) == int'(wd_eff_reg);
    assign row_wrap = (int'(row_reg) + 1) == int'(ht_eff_reg);

    always_comb
    begin
        col_next   = col_reg + CW'(1);
        cph_next   = '0;
        row_next   = row_reg;
        rph_next   = rph_reg;
        wslot_next = wslot_reg;
        chan_next  = chan_reg;
        if (col_ok && (cph_reg + STRIDE_BITS'(1) != s_eff_reg))
            cph_next = cph_reg + STRIDE_BITS'(1);
        if (col_wrap)
        begin
            col_next = '0;
            cph_next = '0;
            if (row_wrap)
            begin
                row_next   = '0;
                rph_next   = '0;
                wslot_next = '0;
                if (int'(chan_reg) + 1 == int'(ch_eff_reg))
                    chan_next = '0;
                else
                    chan_next = chan_reg + CHAN_BITS'(1);
            end
            else
            begin
                row_next = row_reg + ROW_BITS'(1);
                if (row_ok && (rph_reg + STRIDE_BITS'(1) != s_eff_reg))
                    rph_next = rph_reg + STRIDE_BITS'(1);
                else
                    rph_next = '0;
                if (int'(wslot_reg) == LINES - 1)
                    wslot_next = '0;
                else
                    wslot_next = wslot_reg + SB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            chan_reg  <= '0;
            cph_reg   <= '0;
            rph_reg   <= '0;
            wslot_reg <= '0;
        end
        else if (cfg_write && int'(cfg.index) <= int'(REG_CHANNEL_COUNT))
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            chan_reg  <= '0;
            cph_reg   <= '0;
            rph_reg   <= '0;
            wslot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            chan_reg  <= chan_next;
            cph_reg   <= cph_next;
            rph_reg   <= rph_next;
            wslot_reg <= wslot_next;
        end
    end

    // ---------------------------------------------------------------
    // Line buffer: one bank per stored row, read-before-write
    // ---------------------------------------------------------------
    for (genvar b = 0; b < LINES; b++)
    begin : g_line
        logic signed [DATA_BITS-1:0] mem [MAX_WIDTH];
        logic signed [DATA_BITS-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                rd_reg <= mem[col_reg];
                if (int'(wslot_reg) == b)
                    mem[col_reg] <= samples.sample;
            end
        end

        assign line_rd[b] = rd_reg;
    end

    // ---------------------------------------------------------------
    // Stage 1
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= samples.sample;
            s1_slot_reg   <= wslot_reg;
            s1_vert_reg   <= row_ok;
            s1_emit_reg   <= emit;
            s1_last_reg   <= last;
        end
    end

    // Vertical max over the window rows at this column; row r-k sits in
    // bank (slot - k) mod LINES
    always_comb
    begin
        vmax   = s1_sample_reg;
        rd_idx = '0;
        for (int k = 1; k <= LINES; k++)
        begin
            if (int'(s1_slot_reg) >= k)
                rd_idx = SB'(int'(s1_slot_reg) - k);
            else
                rd_idx = SB'(int'(s1_slot_reg) + LINES - k);
            if (s1_vert_reg && k < int'(w_eff_reg) && line_rd[rd_idx] > vmax)
                vmax = line_rd[rd_idx];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_go)
            s2_valid_reg <= 1'b1;
        else if (s2_go)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_emit_reg   <= s1_emit_reg;
            s2_last_reg   <= s1_last_reg;
            colmax_reg[0] <= vmax;
            for (int k = 1; k < MAX_WINDOW; k++)
                colmax_reg[k] <= colmax_reg[k-1];
        end
    end

    always_comb
    begin
        wmax = colmax_reg[0];
        for (int k = 1; k < MAX_WINDOW; k++)
        begin
            if (k < int'(w_eff_reg) && colmax_reg[k] > wmax)
                wmax = colmax_reg[k];
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_go && s2_emit_reg)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_emit_reg)
        begin
            out_max_reg  <= wmax;
            out_last_reg <= s2_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_col_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < wd_eff_reg)
        else $error("column position outside the map");

    a_row_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_reg} < ht_eff_reg)
        else $error("row position outside the map");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        cph_reg < s_eff_reg && rph_reg < s_eff_reg)
        else $error("stride phase out of range");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(wslot_reg) < LINES)
        else $error("line buffer slot out of range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_emit_reg && out_valid_reg && !results.ready
        |=> s2_valid_reg && s2_emit_reg)
        else $error("pending window result dropped while output stalled");

endmodule

FILE: dv/max_pool_2d_stream_tb.sv
module max_pool_2d_stream_tb;
    import mp2d_pkg::*;

    localparam int LINE_BANKS = (DEF_MAX_WINDOW > 1) ? DEF_MAX_WINDOW - 1 : 1;
    localparam int MAX_STRIDE = 15;
    localparam int SETTLE     = 8;    // idle cycles before a register write
    localparam int HOLD_AT    = 100;  // samples taken before the long output stall
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_PCT   = 7;
    localparam int ITEM_COUNT = 850;

    typedef struct {
        bit                           is_write;
        logic [CFG_INDEX_BITS-1:0]    index;
        logic [CFG_DATA_BITS-1:0]     data;
        logic signed [DEF_DATA_BITS-1:0] value;
    } stream_op_t;

    typedef struct {
        logic signed [DEF_DATA_BITS-1:0] pooled;
        bit                              last;
    } pooled_t;

    logic clk = 1'b0;
    logic rst_n;

    always #10 clk = ~clk;

    mp2d_sample_if sample_ch ();
    mp2d_result_if result_ch ();
    mp2d_cfg_if    cfg_ch ();

    max_pool_2d_stream dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    stream_op_t pending_ops[$];
    pooled_t    expected_pools[$];
    int         mismatch_count = 0;
    int         samples_taken;
    int         settle_cycles;
    int         hold_left;
    bit         hold_done;
    logic       steady;

    // model state
    logic signed [DEF_DATA_BITS-1:0] line_rows [LINE_BANKS * DEF_MAX_WIDTH];
    logic signed [DEF_DATA_BITS-1:0] col_max [DEF_MAX_WINDOW];
    logic [WINDOW_REG_BITS-1:0] window_reg = WINDOW_REG_BITS'(2);
    logic [STRIDE_BITS-1:0]     stride_reg = STRIDE_BITS'(2);
    logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_REG_BITS'(256);
    logic [HEIGHT_BITS-1:0]     height_reg = HEIGHT_BITS'(256);
    logic [COUNT_BITS-1:0]      count_reg  = COUNT_BITS'(1);
    int unsigned col_at = 0, row_at = 0, chan_at = 0;

    assign steady = (samples_taken >= 500) && (samples_taken < 750);

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo,
                                             int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                           logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_POOL_WINDOW:   window_reg = data[WINDOW_REG_BITS-1:0];
            REG_POOL_STRIDE:   stride_reg = data[STRIDE_BITS-1:0];
            REG_MAP_WIDTH:     width_reg  = data[WIDTH_REG_BITS-1:0];
            REG_MAP_HEIGHT:    height_reg = data[HEIGHT_BITS-1:0];
            REG_CHANNEL_COUNT: count_reg  = data[COUNT_BITS-1:0];
            default:           return;
        endcase
        col_at  = 0;
        row_at  = 0;
        chan_at = 0;
    endfunction

    // Advances the pooling state by one sample; hit is set when a window completes.
    function automatic void pool_step(input logic signed [DEF_DATA_BITS-1:0] x,
                                      output bit hit, output pooled_t res);
        int unsigned w, s, wd, ht, ch, r, c, slot;
        logic signed [DEF_DATA_BITS-1:0] v, m;
        w  = clamp_to(window_reg, 1, DEF_MAX_WINDOW);
        s  = clamp_to(stride_reg, 1, MAX_STRIDE);
        wd = clamp_to(width_reg, 1, DEF_MAX_WIDTH);
        ht = clamp_to(height_reg, 1, MAX_ROWS);
        ch = clamp_to(count_reg, 1, MAX_CHANNELS);
        r  = row_at;
        c  = col_at;
        hit = 0;
        res = '{default: '0};
        if (c >= wd)
            c = 0;
        if (r >= ht)
            r = 0;
        if (chan_at >= ch)
            chan_at = 0;
        v = x;
        if (r + 1 >= w)
        begin
            for (int unsigned k = 1; k < w; k++)
            begin
                slot = (r - k) % LINE_BANKS;
                if (line_rows[slot * DEF_MAX_WIDTH + c] > v)
                    v = line_rows[slot * DEF_MAX_WIDTH + c];
            end
        end
        for (int k = DEF_MAX_WINDOW - 1; k > 0; k--)
            col_max[k] = col_max[k-1];
        col_max[0] = v;
        line_rows[(r % LINE_BANKS) * DEF_MAX_WIDTH + c] = x;

        if (r + 1 >= w && c + 1 >= w
            && (r + 1 - w) % s == 0 && (c + 1 - w) % s == 0)
        begin
            m = col_max[0];
            for (int unsigned k = 1; k < w; k++)
                if (col_max[k] > m)
                    m = col_max[k];
            hit = 1;
            res.pooled = m;
            res.last = (chan_at == ch - 1) && (r + 1 + s > ht) && (c + 1 + s > wd);
        end

        c++;
        if (c >= wd)
        begin
            c = 0;
            r++;
            if (r >= ht)
            begin
                r = 0;
                chan_at++;
                if (chan_at >= ch)
                    chan_at = 0;
            end
        end
        col_at = c;
        row_at = r;
    endfunction

    function automatic logic signed [DEF_DATA_BITS-1:0] draw_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return $signed(16'($urandom_range(8))) - 16'sd4;  // ties are likely
            default: return DEF_DATA_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_write(logic [CFG_INDEX_BITS-1:0] idx, int value);
        stream_op_t op;
        op = '{default: '0};
        op.is_write = 1;
        op.index = idx;
        op.data = value[CFG_DATA_BITS-1:0];
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic queue_geometry(int win, int stride, int wd, int ht, int ch);
        queue_write(REG_POOL_WINDOW, win);
        queue_write(REG_POOL_STRIDE, stride);
        queue_write(REG_MAP_WIDTH, wd);
        queue_write(REG_MAP_HEIGHT, ht);
        queue_write(REG_CHANNEL_COUNT, ch);
    endtask

    task automatic queue_value(logic signed [DEF_DATA_BITS-1:0] value);
        stream_op_t op;
        op = '{default: '0};
        op.value = value;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic queue_samples(int n);
        for (int i = 0; i < n; i++)
            queue_value(draw_sample());
    endtask

    // sample and register-write driver
    always @(posedge clk or negedge rst_n)
    begin
        stream_op_t head;
        logic s_valid, c_valid;
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= '0;
            cfg_ch.valid     <= 1'b0;
            cfg_ch.index     <= '0;
            cfg_ch.data      <= '0;
        end
        else
        begin
            s_valid = sample_ch.valid && !sample_ch.ready;
            c_valid = cfg_ch.valid && !cfg_ch.ready;
            if (!s_valid && !c_valid && pending_ops.size() != 0
                && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                head = pending_ops[0];
                if (!head.is_write)
                begin
                    sample_ch.sample <= head.value;
                    s_valid = 1'b1;
                    void'(pending_ops.pop_front());
                end
                else if (!sample_ch.valid && !cfg_ch.valid && settle_cycles >= SETTLE)
                begin
                    // block must be empty before any register write
                    cfg_ch.index <= head.index;
                    cfg_ch.data  <= head.data;
                    c_valid = 1'b1;
                    void'(pending_ops.pop_front());
                end
            end
            sample_ch.valid <= s_valid;
            cfg_ch.valid    <= c_valid;
        end
    end

    // result receiver, with one long stall to back up the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= 0;
            hold_done       <= 1'b0;
        end
        else if (!hold_done && samples_taken >= HOLD_AT)
        begin
            hold_left       <= HOLD_LEN;
            hold_done       <= 1'b1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // monitor: predicts on each accepted transfer and checks results in order
    always @(posedge clk or negedge rst_n)
    begin
        bit      hit;
        pooled_t got, want;
        logic    took;
        if (!rst_n)
        begin
            samples_taken <= 0;
            settle_cycles <= 0;
        end
        else
        begin
            took = sample_ch.valid && sample_ch.ready;
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_pools.size() == 0)
                begin
                    $error("unexpected result: pooled_max %0d last_of_volume %0b",
                           result_ch.pooled_max, result_ch.last_of_volume);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pools.pop_front();
                    if (result_ch.pooled_max !== want.pooled)
                    begin
                        $error("pooled_max: expected %0d, got %0d",
                               want.pooled, result_ch.pooled_max);
                        mismatch_count++;
                    end
                    if (result_ch.last_of_volume !== want.last)
                    begin
                        $error("last_of_volume: expected %0b, got %0b",
                               want.last, result_ch.last_of_volume);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                write_register(cfg_ch.index, cfg_ch.data);
            if (took)
            begin
                pool_step(sample_ch.sample, hit, got);
                if (hit)
                    expected_pools.insert(expected_pools.size(), got);
                samples_taken <= samples_taken + 1;
            end
            if (took || expected_pools.size() != 0)
                settle_cycles <= 0;
            else if (settle_cycles < SETTLE)
                settle_cycles <= settle_cycles + 1;
        end
    end

    initial
    begin
        logic signed [DEF_DATA_BITS-1:0] corner_values [16];
        int total, wd, ht, ch, n;
        corner_values = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                          16'sh8000, 16'sh8000, 16'sh0001, 16'shFFFE,
                          16'sh8000, 16'sh8001, 16'shFFFF, 16'shFFFF,
                          16'sh8001, 16'sh8000, 16'sh7FFE, 16'sh7FFF};
        rst_n = 1'b0;

        // two channels of 4x2 with extreme values; writes to unused indexes
        // between channels must not restart the volume
        queue_geometry(2, 2, 4, 2, 2);
        for (int i = 0; i < 8; i++)
            queue_value(corner_values[i]);
        for (int i = REG_CHANNEL_COUNT + 1; i < 2 ** CFG_INDEX_BITS; i++)
            queue_write(CFG_INDEX_BITS'(i), (i % 2) ? 2047 : 0);
        for (int i = 8; i < 16; i++)
            queue_value(corner_values[i]);
        // window larger than the map: nothing comes out
        queue_geometry(5, 1, 3, 3, 1);
        queue_samples(9);

        queue_geometry(1, 1, 256, 1, 1);
        queue_samples(256);
        queue_geometry(1, 8, 1, 256, 1);
        queue_samples(256);
        queue_geometry(8, 1, 9, 9, 1);
        queue_samples(81);
        queue_geometry(2, 15, 18, 2, 2);
        queue_samples(72);
        // zero registers act as one: every sample is its own volume
        queue_geometry(0, 0, 0, 0, 0);
        queue_samples(6);
        // saturated registers, volume cut short
        queue_geometry(15, 15, 511, 511, 2047);
        queue_samples(24);
        queue_geometry(9, 3, 257, 260, 1025);
        queue_samples(12);
        queue_geometry(1, 1, 1, 1, 1024);
        queue_samples(40);

        total = 772;
        while (total < ITEM_COUNT)
        begin
            wd = $urandom_range(1, 12);
            ht = $urandom_range(1, 8);
            ch = $urandom_range(1, 3);
            queue_geometry($urandom_range(1, 4), $urandom_range(1, 4), wd, ht, ch);
            n = wd * ht * ch * $urandom_range(1, 2);
            if ($urandom_range(4) == 0)
                n = $urandom_range(1, n);  // broken volume
            if (n > ITEM_COUNT - total)
                n = ITEM_COUNT - total;
            queue_samples(n);
            total += n;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || sample_ch.valid || expected_pools.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatch_count == 0 && expected_pools.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
